// ----- design/dtd_pkg.sv -----
package dtd_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INEXACT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam int MAX_SIG_DIGITS   = 19;
  localparam int MIN_DEC_EXPONENT = -19;
  localparam int MAX_DEC_EXPONENT = 19;
  localparam int DEFAULT_MAX_TEXT_LENGTH = 4096;

  localparam logic [63:0] INF_BITS  = 64'h7ff0000000000000;
  localparam logic [63:0] NAN_BITS  = 64'h7ff8000000000000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000000000000000;
  localparam int          EXP_BIAS  = 1023;
  localparam int          MIN_BIN_EXP = -1022;
  localparam int          MAX_BIN_EXP = 1023;
  localparam logic [23:0] EXP_ACC_LIMIT = 24'd1000000;
  localparam int          FRAC_BITS = 52;

  // Everything the converter or the output stage needs once a text has ended.
  typedef struct packed {
    logic              convert;
    logic [1:0]        status;
    logic [63:0]       bits;
    logic [12:0]       used;
    logic [63:0]       sig;
    logic signed [5:0] exp10;
    logic              sign;
  } fin_t;

  function automatic logic [7:0] inf_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h69;
      3'd1: c = 8'h6e;
      3'd2: c = 8'h66;
      3'd3: c = 8'h69;
      3'd4: c = 8'h6e;
      3'd5: c = 8'h69;
      3'd6: c = 8'h74;
      default: c = 8'h79;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] nan_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd1: c = 8'h61;
      default: c = 8'h6e;
    endcase
    return c;
  endfunction

endpackage

// ----- design/dtd_parse.sv -----
module dtd_parse #(
  parameter int MAX_TEXT_LENGTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    char_byte,
  input  logic          clear,
  output dtd_pkg::fin_t fin
);
  import dtd_pkg::*;

  localparam int PW = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int EW = $clog2(MAX_TEXT_LENGTH + 9);

  typedef enum logic [3:0] {
    P_WS, P_START, P_INT, P_FRAC, P_EXP_MARK, P_EXP_SIGNED, P_EXP_DIG, P_NUM_DONE,
    P_INF, P_NAN, P_INF_DONE, P_NAN_DONE, P_INVALID
  } phase_t;

  phase_t             phase, phase_next;
  logic               sign, sign_next;
  logic [63:0]        acc, acc_next;
  logic [4:0]         cnt, cnt_next;
  logic signed [31:0] dec_exp, dec_exp_next;
  logic [23:0]        exp_acc, exp_acc_next;
  logic               any, any_next, nonzero, nonzero_next;
  logic               too_many, too_many_next, exp_neg, exp_neg_next;
  logic [PW-1:0]      pos;
  logic [EW-1:0]      end_pos, end_pos_next;
  logic [3:0]         prog, prog_next;

  logic [7:0] lc;
  logic [3:0] dval;
  logic       is_dig, is_sp, is_sign;
  logic       go_start, go_int, take_dig, frac_dig, do_end, exp_dig;
  logic [EW-1:0] pos_e;

  assign pos_e = EW'(pos);

  always_comb begin
    lc       = (char_byte >= 8'h41 && char_byte <= 8'h5a) ? char_byte + 8'd32 : char_byte;
    is_dig   = char_byte >= 8'h30 && char_byte <= 8'h39;
    dval     = 4'(char_byte - 8'h30);
    is_sp    = char_byte == 8'h20 || (char_byte >= 8'd9 && char_byte <= 8'd13);
    is_sign  = char_byte == 8'h2b || char_byte == 8'h2d;
    phase_next = phase; sign_next = sign; acc_next = acc; cnt_next = cnt;
    dec_exp_next = dec_exp; exp_acc_next = exp_acc; any_next = any;
    nonzero_next = nonzero; too_many_next = too_many; exp_neg_next = exp_neg;
    end_pos_next = end_pos; prog_next = prog;
    go_start = 1'b0; go_int = 1'b0; take_dig = 1'b0; frac_dig = 1'b0;
    do_end = 1'b0; exp_dig = 1'b0;
    unique case (phase)
      P_WS: begin
        if (is_sp) begin
        end else if (is_sign) begin
          sign_next  = char_byte == 8'h2d;
          phase_next = P_START;
        end else begin
          go_start = 1'b1;
        end
      end
      P_START: go_start = 1'b1;
      P_INT: go_int = 1'b1;
      P_FRAC: begin
        if (is_dig) begin
          take_dig = 1'b1;
          frac_dig = 1'b1;
        end else begin
          do_end = 1'b1;
        end
      end
      P_EXP_MARK: begin
        if (is_sign) begin
          exp_neg_next = char_byte == 8'h2d;
          phase_next   = P_EXP_SIGNED;
        end else if (is_dig) begin
          exp_dig = 1'b1;
        end else begin
          phase_next = P_NUM_DONE;
        end
      end
      P_EXP_SIGNED, P_EXP_DIG: begin
        if (is_dig) exp_dig = 1'b1;
        else phase_next = P_NUM_DONE;
      end
      P_INF: begin
        if (prog < 4'd8 && lc == inf_char(prog[2:0])) begin
          prog_next = prog + 4'd1;
          if (prog == 4'd7) begin
            end_pos_next = end_pos + EW'(8);
            phase_next   = P_INF_DONE;
          end
        end else if (prog >= 4'd3) begin
          end_pos_next = end_pos + EW'(3);
          phase_next   = P_INF_DONE;
        end else begin
          phase_next = P_INVALID;
        end
      end
      P_NAN: begin
        if (prog < 4'd3 && lc == nan_char(prog[1:0])) begin
          prog_next = prog + 4'd1;
          if (prog == 4'd2) begin
            end_pos_next = end_pos + EW'(3);
            phase_next   = P_NAN_DONE;
          end
        end else begin
          phase_next = P_INVALID;
        end
      end
      default: begin
      end
    endcase
    if (go_start) begin
      end_pos_next = pos_e;
      if (lc == 8'h69) begin
        phase_next = P_INF;
        prog_next  = 4'd1;
      end else if (lc == 8'h6e) begin
        phase_next = P_NAN;
        prog_next  = 4'd1;
      end else begin
        phase_next = P_INT;
        go_int     = 1'b1;
      end
    end
    if (go_int) begin
      if (is_dig) take_dig = 1'b1;
      else if (char_byte == 8'h2e) phase_next = P_FRAC;
      else do_end = 1'b1;
    end
    if (take_dig) begin
      any_next = 1'b1;
      if (dval != 4'd0 || nonzero) begin
        nonzero_next = 1'b1;
        if (32'(cnt) < MAX_SIG_DIGITS) begin
          acc_next = (acc << 3) + (acc << 1) + 64'(dval);
          cnt_next = cnt + 5'd1;
        end else begin
          too_many_next = 1'b1;
        end
      end
      if (frac_dig) dec_exp_next = dec_exp - 32'sd1;
    end
    if (do_end) begin
      if (!any) begin
        phase_next = P_INVALID;
      end else begin
        end_pos_next = pos_e;
        phase_next = (lc == 8'h65) ? P_EXP_MARK : P_NUM_DONE;
      end
    end
    if (exp_dig) begin
      if (exp_acc < EXP_ACC_LIMIT) exp_acc_next = (exp_acc << 3) + (exp_acc << 1) + 24'(dval);
      end_pos_next = pos_e + EW'(1);
      phase_next   = P_EXP_DIG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= P_WS; sign <= 1'b0; acc <= '0; cnt <= '0; dec_exp <= '0; exp_acc <= '0;
      any <= 1'b0; nonzero <= 1'b0; too_many <= 1'b0; exp_neg <= 1'b0;
      pos <= '0; end_pos <= '0; prog <= '0;
    end else if (take && 32'(pos) < MAX_TEXT_LENGTH) begin
      phase <= phase_next; sign <= sign_next; acc <= acc_next; cnt <= cnt_next;
      dec_exp <= dec_exp_next; exp_acc <= exp_acc_next; any <= any_next;
      nonzero <= nonzero_next; too_many <= too_many_next; exp_neg <= exp_neg_next;
      pos <= pos + PW'(1); end_pos <= end_pos_next; prog <= prog_next;
    end
  end

  // End-of-text decode from the settled parse state.
  phase_t             ph_e;
  logic [EW-1:0]      end_e;
  logic signed [32:0] e_tot;
  logic [31:0]        used32;

  always_comb begin
    fin        = '0;
    fin.status = ST_INVALID;
    ph_e       = phase;
    end_e      = end_pos;
    used32     = '0;
    e_tot = 33'(dec_exp) + (exp_neg ? -$signed({9'd0, exp_acc}) : $signed({9'd0, exp_acc}));
    if (phase == P_INT || phase == P_FRAC) begin
      if (!any) begin
        ph_e = P_INVALID;
      end else begin
        ph_e  = P_NUM_DONE;
        end_e = pos_e;
      end
    end
    if (phase == P_INF && prog >= 4'd3) begin
      ph_e  = P_INF_DONE;
      end_e = end_pos + EW'(3);
    end
    if (ph_e == P_INF_DONE || ph_e == P_NAN_DONE) begin
      fin.bits   = ((ph_e == P_INF_DONE) ? INF_BITS : NAN_BITS) | (sign ? SIGN_BIT : 64'd0);
      fin.status = ST_OK;
      used32     = 32'(end_e);
    end else if (ph_e == P_EXP_MARK || ph_e == P_EXP_SIGNED || ph_e == P_EXP_DIG ||
                 ph_e == P_NUM_DONE) begin
      used32 = 32'(end_e);
      if (!nonzero) begin
        fin.status = ST_OK;
        fin.bits   = sign ? SIGN_BIT : 64'd0;
      end else if (too_many || e_tot < 33'(MIN_DEC_EXPONENT) ||
                   e_tot > 33'(MAX_DEC_EXPONENT)) begin
        fin.status = ST_RANGE;
      end else begin
        fin.convert = 1'b1;
        fin.sig     = acc;
        fin.exp10   = e_tot[5:0];
        fin.sign    = sign;
      end
    end
    fin.used = used32[12:0];
  end

endmodule

// ----- design/dtd_conv.sv -----
module dtd_conv (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       sig,
  input  logic signed [5:0] exp10,
  input  logic              sign,
  output logic              done,
  output logic [1:0]        status,
  output logic [63:0]       bits
);
  import dtd_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_SCALE, C_NORM, C_DIV, C_ROUND} cstate_t;

  cstate_t            state;
  logic [127:0]       num, den, rem;
  logic [4:0]         cnt;
  logic               neg_e, neg;
  logic signed [9:0]  q2;
  logic [5:0]         step;
  logic [51:0]        frac;
  logic               guard, rnd;

  // The combinational datapath: a 128-bit shift, subtract and compare for the division, times-ten scaling and rounding.
  logic [127:0] rem2, diff, sh_num, sh_den;
  logic         ge;
  logic [53:0]  mant;
  logic         sticky, inc;
  logic signed [9:0] q2f;
  logic [10:0]  bexp;

  always_comb begin
    rem2   = rem << 1;
    ge     = rem2 >= den;
    diff   = rem2 - den;
    sh_num = (num << 3) + (num << 1);
    sh_den = (den << 3) + (den << 1);
    sticky = rem != '0;
    inc    = guard && (rnd || sticky || frac[0]);
    mant   = {2'b01, frac} + 54'(inc);
    q2f    = mant[53] ? q2 + 10'sd1 : q2;
    bexp   = 11'(q2f) + 11'(EXP_BIAS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            num   <= {64'd0, sig};
            den   <= 128'd1;
            neg_e <= exp10 < 0;
            cnt   <= 5'((exp10 < 0) ? -exp10 : exp10);
            neg   <= sign;
            q2    <= '0;
            state <= C_SCALE;
          end
        end
        C_SCALE: begin
          if (cnt == 5'd0) begin
            state <= C_NORM;
          end else begin
            if (neg_e) den <= sh_den;
            else num <= sh_num;
            cnt <= cnt - 5'd1;
          end
        end
        C_NORM: begin
          if (num >= den) begin
            if ({1'b0, num} >= {den, 1'b0}) begin
              den <= den << 1;
              q2  <= q2 + 10'sd1;
            end else begin
              rem   <= num - den;
              step  <= '0;
              state <= C_DIV;
            end
          end else begin
            num <= num << 1;
            q2  <= q2 - 10'sd1;
          end
        end
        C_DIV: begin
          rem <= ge ? diff : rem2;
          if (32'(step) < FRAC_BITS) frac <= {frac[50:0], ge};
          else if (32'(step) == FRAC_BITS) guard <= ge;
          else rnd <= ge;
          step <= step + 6'd1;
          if (32'(step) == FRAC_BITS + 1) state <= C_ROUND;
        end
        C_ROUND: begin
          done  <= 1'b1;
          state <= C_IDLE;
          if (int'(q2f) > MAX_BIN_EXP || int'(q2f) < MIN_BIN_EXP) begin
            status <= ST_RANGE;
            bits   <= '0;
          end else begin
            status <= (guard || rnd || sticky) ? ST_INEXACT : ST_OK;
            bits   <= {neg, bexp, mant[53] ? mant[52:1] : mant[51:0]};
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- design/decimal_text_to_double_unit.sv -----
// Decimal text to binary64 converter.
// Input channel: in_valid/in_stall carry one ASCII byte per transfer in char_byte, with
// last_char set on the final byte of a text. While a text is being read, a byte is taken
// in every cycle in which in_valid is high. Leading whitespace, a sign, the words inf,
// infinity and nan, and decimal numbers with fraction and exponent are recognized.
// Output channel: out_valid/out_stall carry exactly one result per text: status,
// value_bits and consumed (bytes that form the number, including whitespace and sign).
// After the final byte, specials, zero, invalid and out-of-range texts are decoded in
// S_FIN and their result is registered for S_OUT. A text that needs conversion runs the
// converter's 128-bit datapath: one scale-by-ten step per unit of the decimal exponent
// (up to 19), the normalizing shifts, 54 long-division steps and one rounding step.
// The block works on one text at a time: in_stall is high from the cycle after the final
// byte until the result has been taken. A stalled result holds on the outputs.
// Reset (rst, synchronous, active high) returns the parser to whitespace skipping and
// drops any pending result.
module decimal_text_to_double_unit #(
  parameter int MAX_TEXT_LENGTH = dtd_pkg::DEFAULT_MAX_TEXT_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] value_bits,
  output logic [12:0] consumed
);
  import dtd_pkg::*;

  typedef enum logic [1:0] {S_IN, S_FIN, S_CONV, S_OUT} state_t;

  state_t      state;
  fin_t        fin;
  logic        acc;
  logic        clear;
  logic        conv_start;
  logic        conv_done;
  logic [1:0]  conv_status;
  logic [63:0] conv_bits;

  assign in_stall   = state != S_IN;
  assign out_valid  = state == S_OUT;
  assign acc        = in_valid && !in_stall;
  assign clear      = state == S_FIN;
  assign conv_start = state == S_FIN && fin.convert;

  dtd_parse #(.MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)) u_parse (
    .clk(clk), .rst(rst), .take(acc), .char_byte(char_byte), .clear(clear), .fin(fin)
  );

  dtd_conv u_conv (
    .clk(clk), .rst(rst), .start(conv_start), .sig(fin.sig), .exp10(fin.exp10),
    .sign(fin.sign), .done(conv_done), .status(conv_status), .bits(conv_bits)
  );

  // The parser state is settled in the cycle after the final byte; it is decoded then.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      unique case (state)
        S_IN: begin
          if (acc && last_char) state <= S_FIN;
        end
        S_FIN: begin
          consumed <= fin.used;
          if (fin.convert) begin
            state <= S_CONV;
          end else begin
            status     <= fin.status;
            value_bits <= fin.bits;
            state      <= S_OUT;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            status     <= conv_status;
            value_bits <= conv_bits;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IN;
        end
        default: state <= S_IN;
      endcase
    end
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a result is pending");
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == S_CONV) else $error("converter finished outside conversion");
  a_last_to_fin: assert property (@(posedge clk) disable iff (rst)
    (acc && last_char) |=> state == S_FIN) else $error("final byte not decoded");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_INVALID || status == ST_RANGE)) |-> value_bits == 64'd0)
    else $error("error result carries nonzero bits");

endmodule

// ----- tb/sv/decimal_text_to_double_unit_tb.sv -----
module decimal_text_to_double_unit_tb;
  import dtd_pkg::*;

  // Parser phases of the predictor. They mirror the way the block walks through a text.
  typedef enum int {
    P_WS, P_START, P_INT, P_FRAC, P_EXP_MARK, P_EXP_SIGNED, P_EXP_DIG, P_NUM_DONE,
    P_INF, P_NAN, P_INF_DONE, P_NAN_DONE, P_INVALID
  } phase_e;

  typedef struct {
    logic [1:0]  st;
    logic [63:0] bits;
    logic [12:0] used;
  } conv_result_t;

  // Scoreboard: follows the text byte by byte and predicts the one result that the
  // final byte of each text produces. Results are checked in order.
  class conversion_scoreboard;
    phase_e      ph;
    bit          neg, any_digit, nonzero, too_many, exp_neg;
    logic [63:0] sig;
    int          nsig, dexp, eacc, pos, endp, wprog;
    conv_result_t pending_q[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = P_WS; neg = 0; any_digit = 0; nonzero = 0; too_many = 0; exp_neg = 0;
      sig = 0; nsig = 0; dexp = 0; eacc = 0; pos = 0; endp = 0; wprog = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    function int bit_length(logic [127:0] x);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) if (x[i]) n = i + 1;
      return n;
    endfunction

    // Scales m by ten to the e, then finds 54 quotient bits by long division and
    // rounds to nearest even.
    function void scale_and_round(logic [63:0] m, int e, output logic [1:0] st,
                                  output logic [63:0] bits);
      logic [127:0] num, den, rem, p;
      logic [51:0]  frac;
      logic [53:0]  mant;
      int           q2;
      bit           guard, rnd, sticky, qbit;
      p = 1;
      for (int i = 0; i < (e < 0 ? -e : e); i++) p = p * 10;
      bits = 0;
      frac = 0; guard = 0; rnd = 0;
      if (e >= 0) begin
        num = 128'(m) * p;
        den = 1;
      end else begin
        num = 128'(m);
        den = p;
      end
      q2 = bit_length(num) - bit_length(den);
      if (q2 >= 0) begin
        if (num < (den << q2)) q2--;
      end else if ((num << (-q2)) < den) begin
        q2--;
      end
      if (q2 >= 0) den = den << q2;
      else num = num << (-q2);
      rem = num - den;
      for (int i = 0; i < 54; i++) begin
        rem = rem << 1;
        qbit = 0;
        if (rem >= den) begin
          rem = rem - den;
          qbit = 1;
        end
        if (i < 52) frac = {frac[50:0], qbit};
        else if (i == 52) guard = qbit;
        else rnd = qbit;
      end
      sticky = (rem != 0);
      mant = {2'b01, frac};
      if (guard && (rnd || sticky || mant[0])) mant = mant + 1;
      if (mant[53]) begin
        mant = mant >> 1;
        q2++;
      end
      if (q2 > MAX_BIN_EXP || q2 < MIN_BIN_EXP) begin
        st = ST_RANGE;
        return;
      end
      bits = {neg, 11'(q2 + EXP_BIAS), mant[51:0]};
      st = (guard || rnd || sticky) ? ST_INEXACT : ST_OK;
    endfunction

    function void take_digit(int d, bit in_fraction);
      any_digit = 1;
      if (d != 0 || nonzero) begin
        nonzero = 1;
        if (nsig < MAX_SIG_DIGITS) begin
          sig = sig * 10 + 64'(d);
          nsig++;
        end else begin
          too_many = 1;
        end
      end
      if (in_fraction) dexp--;
    endfunction

    function void end_digits(logic [7:0] c, bit have_char);
      if (!any_digit) begin
        ph = P_INVALID;
        return;
      end
      endp = pos;
      ph = (have_char && (c == "e" || c == "E")) ? P_EXP_MARK : P_NUM_DONE;
    endfunction

    function void take_exp_digit(logic [7:0] c);
      if (eacc < int'(EXP_ACC_LIMIT)) eacc = eacc * 10 + int'(c - "0");
      endp = pos + 1;
      ph = P_EXP_DIG;
    endfunction

    function void parse(logic [7:0] c);
      logic [7:0] lc;
      bit         is_dig, is_ws;
      string      w_inf, w_nan;
      w_inf = "infinity";
      w_nan = "nan";
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      is_dig = (c >= "0" && c <= "9");
      is_ws = (c == " " || (c >= 8'd9 && c <= 8'd13));
      if (ph == P_WS) begin
        if (is_ws) return;
        if (c == "+" || c == "-") begin
          neg = (c == "-");
          ph = P_START;
          return;
        end
        ph = P_START;
      end
      if (ph == P_START) begin
        endp = pos;
        if (lc == "i") begin
          ph = P_INF;
          wprog = 1;
          return;
        end
        if (lc == "n") begin
          ph = P_NAN;
          wprog = 1;
          return;
        end
        ph = P_INT;
      end
      case (ph)
        P_INT: begin
          if (is_dig) take_digit(int'(c - "0"), 0);
          else if (c == ".") ph = P_FRAC;
          else end_digits(c, 1);
        end
        P_FRAC: begin
          if (is_dig) take_digit(int'(c - "0"), 1);
          else end_digits(c, 1);
        end
        P_EXP_MARK: begin
          if (c == "+" || c == "-") begin
            if (c == "-") exp_neg = 1;
            ph = P_EXP_SIGNED;
          end else if (is_dig) begin
            take_exp_digit(c);
          end else begin
            ph = P_NUM_DONE;
          end
        end
        P_EXP_SIGNED, P_EXP_DIG: begin
          if (is_dig) take_exp_digit(c);
          else ph = P_NUM_DONE;
        end
        P_INF: begin
          if (wprog < 8 && lc == w_inf[wprog]) begin
            wprog++;
            if (wprog == 8) begin
              endp += 8;
              ph = P_INF_DONE;
            end
          end else if (wprog >= 3) begin
            endp += 3;
            ph = P_INF_DONE;
          end else begin
            ph = P_INVALID;
          end
        end
        P_NAN: begin
          if (wprog < 3 && lc == w_nan[wprog]) begin
            wprog++;
            if (wprog == 3) begin
              endp += 3;
              ph = P_NAN_DONE;
            end
          end else begin
            ph = P_INVALID;
          end
        end
        default: ;
      endcase
    endfunction

    function void close_text();
      conv_result_t r;
      longint       e;
      r.st = ST_INVALID;
      r.bits = 0;
      r.used = 0;
      if (ph == P_INT || ph == P_FRAC) end_digits(8'd0, 0);
      if (ph == P_INF && wprog >= 3) begin
        endp += 3;
        ph = P_INF_DONE;
      end
      if (ph == P_INF_DONE || ph == P_NAN_DONE) begin
        r.bits = (ph == P_INF_DONE) ? INF_BITS : NAN_BITS;
        if (neg) r.bits |= SIGN_BIT;
        r.st = ST_OK;
        r.used = endp[12:0];
      end else if (ph >= P_EXP_MARK && ph <= P_NUM_DONE) begin
        r.used = endp[12:0];
        e = longint'(dexp) + (exp_neg ? -longint'(eacc) : longint'(eacc));
        if (!nonzero) begin
          r.st = ST_OK;
          r.bits = neg ? SIGN_BIT : 64'd0;
        end else if (too_many || e < MIN_DEC_EXPONENT || e > MAX_DEC_EXPONENT) begin
          r.st = ST_RANGE;
        end else begin
          scale_and_round(sig, int'(e), r.st, r.bits);
        end
      end
      pending_q.push_back(r);
      clear();
    endfunction

    // Notes one accepted byte. Bytes past the length limit only matter for the mark.
    function void note_byte(logic [7:0] c, logic last);
      if (pos < DEFAULT_MAX_TEXT_LENGTH) begin
        parse(c);
        pos++;
      end
      if (last) close_text();
    endfunction

    task check_result(logic [1:0] st, logic [63:0] bits, logic [12:0] used);
      conv_result_t w;
      if (pending_q.size() == 0) begin
        report("result with nothing pending", {st, used}, 0);
        return;
      end
      w = pending_q.pop_front();
      if (st !== w.st) report("status", st, w.st);
      if (bits !== w.bits) report("value_bits", bits, w.bits);
      if (used !== w.used) report("consumed", used, w.used);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_byte;
  logic        last_char;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] value_bits;
  logic [12:0] consumed;

  conversion_scoreboard sb = new();
  logic [7:0] text_buf[$];
  bit         hold_request = 0;
  bit         quiet_mode = 0;
  int         bytes_sent = 0;

  decimal_text_to_double_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .char_byte(char_byte), .last_char(last_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .value_bits(value_bits), .consumed(consumed)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // Both channels are watched at the clock edge; values read here are the ones that
  // were stable before the edge, so a transfer is seen exactly when the block sees it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(char_byte, last_char);
      if (out_valid && !out_stall) sb.check_result(status, value_bits, consumed);
    end
  end

  // Most gaps are short, a few are long. Quiet stretches turn idling off entirely.
  function int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_byte(logic [7:0] c, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_byte <= c;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task push_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task push_digits(int n, bit allow_zero_lead);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && !allow_zero_lead) text_buf.push_back(8'(49 + $urandom_range(0, 8)));
      else text_buf.push_back(8'(48 + $urandom_range(0, 9)));
    end
  endtask

  // Random word text: a prefix of "infinity" or "nan" in mixed case, sometimes with
  // a tail that breaks the word.
  task make_word_text();
    string w;
    int    n;
    logic [7:0] c;
    w = ($urandom_range(0, 1) == 0) ? "infinity" : "nan";
    n = $urandom_range(1, w.len());
    if ($urandom_range(0, 2) == 0) push_str($urandom_range(0, 1) ? "-" : "+");
    for (int i = 0; i < n; i++) begin
      c = w[i];
      if ($urandom_range(0, 1)) c = c - 8'd32;
      text_buf.push_back(c);
    end
    if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random well-formed number, mostly small enough to need a real conversion.
  task make_number_text();
    int nint, nfrac;
    string ws;
    ws = " \t\n";
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 3) == 0) text_buf.push_back(8'($urandom_range(11, 13)));
      else text_buf.push_back(ws[$urandom_range(0, 2)]);
    end
    case ($urandom_range(0, 3))
      0: push_str("-");
      1: push_str("+");
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) push_str("00");
    nint = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 23) : $urandom_range(0, 8);
    nfrac = $urandom_range(0, 5);
    push_digits(nint, 0);
    if (nint == 0 || $urandom_range(0, 1)) begin
      push_str(".");
      push_digits(nfrac, 1);
      if (nint == 0 && nfrac == 0) push_digits(1, 1);
    end
    if ($urandom_range(0, 2) == 0) begin
      push_str($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: push_str("-");
        1: push_str("+");
        default: ;
      endcase
      if ($urandom_range(0, 14) == 0) push_digits($urandom_range(3, 8), 1);
      else push_digits($urandom_range(1, 2), 1);
    end
    if ($urandom_range(0, 4) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Broken texts and raw noise.
  task make_broken_text();
    string pieces[8];
    pieces = '{"-", " ", ".", "e5", "1e", "1e+", "+.", "\t \r"};
    if ($urandom_range(0, 1)) begin
      push_str(pieces[$urandom_range(0, 7)]);
    end else begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Stall pattern of the receiver. On request it holds off for a long stretch so that
  // the block fills up and stalls its input.
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    string directed[22];
    int    ntext, waited;
    directed = '{"0", "-0.000", "inf", "-Infinity", "NaN", "in", "na", "infx", "+",
                 "  +1.5e3x", "1e", "12345678901234567890", "1e20", "1e-20", "0.1",
                 "9999999999999999999", "1e0000005", "1e99999999", "\v\f\r7", "12.5E-3",
                 "nanx", "-"};
    rst = 1'b1;
    in_valid = 1'b0;
    char_byte = 8'd0;
    last_char = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed texts: extremes, all words, and the special cases.
    foreach (directed[k]) begin
      text_buf.delete();
      push_str(directed[k]);
      send_text();
    end
    text_buf.delete();
    text_buf.push_back(8'hff);
    send_text();

    // Random texts, with a long hold-off from the receiver and a drain pause mixed in.
    ntext = 0;
    while (bytes_sent < 1350) begin
      ntext++;
      text_buf.delete();
      if (ntext % 25 == 0) quiet_mode = ~quiet_mode;
      if (ntext == 20) hold_request = 1;
      if (ntext == 60) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      if (ntext == 90) begin
        // A long run of leading whitespace before the digits.
        repeat (60) text_buf.push_back(" ");
        push_str("1234");
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: make_number_text();
          7: make_word_text();
          default: make_broken_text();
        endcase
      end
      send_text();
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_q.size() != 0) begin
      $display("status: fail");
      $finish;
    end else begin
      repeat (300) @(posedge clk);
      if (sb.errors == 0 && sb.pending_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
    end
  end

endmodule
